// ===== design/slle_pkg.sv =====
`timescale 1ns / 1ps

package slle_pkg;

  // Fixed field widths of the request and response items
  localparam int unsigned POS_W   = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 10;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // Response status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Response handed from the sequencer to the output stage
  typedef struct packed {
    logic             status;
    logic [LEN_W-1:0] list_length;
  } slle_rsp_t;

endpackage

// ===== design/static_linked_list_engine.sv =====
`timescale 1ns / 1ps
// Channel  Ports                                            Direction
// in       in_valid, in_stall, in_req_type, in_position,    request in
//          in_value
// out      out_valid, out_stall, out_status, out_list_length result out
//
// Insert and delete requests walk the list from its head; the cursor walk does
// one read of the cursor store a cycle. After reset a clearing pass writes
// every entry of the cursor store with in_stall high. Synchronous active-low
// reset clears control state only. A result waits in an output register while
// the next request is taken; while it is stalled a finished request holds the
// sequencer.

module static_linked_list_engine
  import slle_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [POS_W-1:0]   in_position,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic [LEN_W-1:0]   out_list_length
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic            req_ready;
  logic            rsp_valid;
  logic            rsp_ready;
  slle_rsp_t       rsp;
  logic            out_valid_r;
  slle_rsp_t       out_rsp_r;

  logic            nx_wr_en;
  logic [AW-1:0]   nx_wr_addr;
  logic [AW-1:0]   nx_wr_data;
  logic            nx_rd_en;
  logic [AW-1:0]   nx_rd_addr;
  logic [AW-1:0]   nx_rd_data;
  logic            val_wr_en;
  logic [AW-1:0]   val_wr_addr;
  logic [VALUE_W-1:0] val_wr_data;

  assign in_stall = !req_ready;

  slle_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_valid),
    .req_ready   (req_ready),
    .req_type    (in_req_type),
    .req_pos     (in_position),
    .req_value   (in_value),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .nx_wr_en    (nx_wr_en),
    .nx_wr_addr  (nx_wr_addr),
    .nx_wr_data  (nx_wr_data),
    .nx_rd_en    (nx_rd_en),
    .nx_rd_addr  (nx_rd_addr),
    .nx_rd_data  (nx_rd_data),
    .val_wr_en   (val_wr_en),
    .val_wr_addr (val_wr_addr),
    .val_wr_data (val_wr_data)
  );

  // Cursor store: next links of both chains
  slle_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_next_ram (
    .clk     (clk),
    .wr_en   (nx_wr_en),
    .wr_addr (nx_wr_addr),
    .wr_data (nx_wr_data),
    .rd_en   (nx_rd_en),
    .rd_addr (nx_rd_addr),
    .rd_data (nx_rd_data)
  );

  // Element values; nothing here reads them back
  slle_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (val_wr_addr),
    .wr_data (val_wr_data),
    .rd_en   (1'b0),
    .rd_addr ({AW{1'b0}}),
    .rd_data ()
  );

  // Output register: frees the sequencer as soon as the result is parked
  assign rsp_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_r <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_rsp_r.status;
  assign out_list_length = out_rsp_r.list_length;

endmodule

// ===== design/slle_ram.sv =====
`timescale 1ns / 1ps

module slle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/slle_ctrl.sv =====
`timescale 1ns / 1ps

module slle_ctrl
  import slle_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request side
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic                     req_type,
  input  logic [POS_W-1:0]         req_pos,
  input  logic [VALUE_W-1:0]       req_value,
  // response side
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output slle_rsp_t                rsp,
  // cursor store
  output logic                     nx_wr_en,
  output logic [$clog2(DEPTH)-1:0] nx_wr_addr,
  output logic [$clog2(DEPTH)-1:0] nx_wr_data,
  output logic                     nx_rd_en,
  output logic [$clog2(DEPTH)-1:0] nx_rd_addr,
  input  logic [$clog2(DEPTH)-1:0] nx_rd_data,
  // value store
  output logic                     val_wr_en,
  output logic [$clog2(DEPTH)-1:0] val_wr_addr,
  output logic [VALUE_W-1:0]       val_wr_data
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CMPW = ((AW > POS_W) ? AW : POS_W) + 1;

  // Slot 0 heads the free chain, the last slot heads the list
  localparam logic [AW-1:0] FREE_HEAD = '0;
  localparam logic [AW-1:0] LIST_HEAD = AW'(DEPTH - 1);
  localparam logic [AW-1:0] FREE_LAST = AW'(DEPTH - 2);
  localparam logic [AW-1:0] MAX_COUNT = AW'(DEPTH - 2);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_INS_RD0,
    S_INS_RDF,
    S_INS_UPF,
    S_WREQ,
    S_WSTEP,
    S_INS_LNK,
    S_DEL_RG,
    S_DEL_R0,
    S_DEL_W0,
    S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        init_idx_r, init_idx_nxt;
  logic [AW-1:0]        count_r, count_nxt;
  logic                 err_r, err_nxt;
  logic                 type_r, type_nxt;
  logic [POS_W-1:0]     steps_r, steps_nxt;
  logic [AW-1:0]        at_r, at_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic [VALUE_W-1:0]   value_r, value_nxt;

  logic [CMPW-1:0]      pos_ext;
  logic [CMPW-1:0]      cnt_ext;
  logic                 pos_bad;

  // Position range check against the current length
  assign pos_ext = CMPW'(req_pos);
  assign cnt_ext = CMPW'(count_r);
  always_comb begin
    if (req_type == REQ_INSERT) begin
      pos_bad = (req_pos == '0) || (pos_ext > cnt_ext + 1'b1);
    end else begin
      pos_bad = (req_pos == '0) || (pos_ext > cnt_ext);
    end
  end

  assign req_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_RESP);
  assign rsp.status      = err_r ? STATUS_ERR : STATUS_OK;
  assign rsp.list_length = cnt_ext[LEN_W-1:0];

  // Sequencer: next state and store accesses
  always_comb begin
    state_nxt    = state_r;
    init_idx_nxt = init_idx_r;
    count_nxt    = count_r;
    err_nxt      = err_r;
    type_nxt     = type_r;
    steps_nxt    = steps_r;
    at_nxt       = at_r;
    slot_nxt     = slot_r;
    value_nxt    = value_r;

    nx_wr_en    = 1'b0;
    nx_wr_addr  = '0;
    nx_wr_data  = '0;
    nx_rd_en    = 1'b0;
    nx_rd_addr  = '0;
    val_wr_en   = 1'b0;
    val_wr_addr = slot_r;
    val_wr_data = value_r;

    unique case (state_r)
      S_INIT: begin
        // clearing pass: entry i links to i+1, both chain ends hold 0
        nx_wr_en   = 1'b1;
        nx_wr_addr = init_idx_r;
        nx_wr_data = (init_idx_r >= FREE_LAST) ? '0 : init_idx_r + 1'b1;
        init_idx_nxt = init_idx_r + 1'b1;
        if (init_idx_r == LIST_HEAD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          type_nxt  = req_type;
          value_nxt = req_value;
          steps_nxt = req_pos - 1'b1;
          at_nxt    = LIST_HEAD;
          err_nxt   = pos_bad;
          if (pos_bad) begin
            state_nxt = S_RESP;
          end else if (req_type == REQ_INSERT) begin
            state_nxt = S_INS_RD0;
          end else begin
            state_nxt = S_WREQ;
          end
        end
      end
      S_INS_RD0: begin
        nx_rd_en   = 1'b1;
        nx_rd_addr = FREE_HEAD;
        state_nxt  = S_INS_RDF;
      end
      S_INS_RDF: begin
        // first free slot; an empty free chain is an error
        if (nx_rd_data == FREE_HEAD) begin
          err_nxt   = 1'b1;
          state_nxt = S_RESP;
        end else begin
          slot_nxt    = nx_rd_data;
          nx_rd_en    = 1'b1;
          nx_rd_addr  = nx_rd_data;
          val_wr_en   = 1'b1;
          val_wr_addr = nx_rd_data;
          state_nxt   = S_INS_UPF;
        end
      end
      S_INS_UPF: begin
        // unhook the slot from the free chain
        nx_wr_en   = 1'b1;
        nx_wr_addr = FREE_HEAD;
        nx_wr_data = nx_rd_data;
        state_nxt  = S_WREQ;
      end
      S_WREQ: begin
        nx_rd_en   = 1'b1;
        nx_rd_addr = at_r;
        state_nxt  = S_WSTEP;
      end
      S_WSTEP: begin
        // one cursor hop a cycle; read data feeds the next address
        if (steps_r == '0) begin
          if (type_r == REQ_INSERT) begin
            nx_wr_en   = 1'b1;
            nx_wr_addr = slot_r;
            nx_wr_data = nx_rd_data;
            state_nxt  = S_INS_LNK;
          end else begin
            slot_nxt   = nx_rd_data;
            nx_rd_en   = 1'b1;
            nx_rd_addr = nx_rd_data;
            state_nxt  = S_DEL_RG;
          end
        end else begin
          at_nxt     = nx_rd_data;
          steps_nxt  = steps_r - 1'b1;
          nx_rd_en   = 1'b1;
          nx_rd_addr = nx_rd_data;
        end
      end
      S_INS_LNK: begin
        nx_wr_en   = 1'b1;
        nx_wr_addr = at_r;
        nx_wr_data = slot_r;
        count_nxt  = count_r + 1'b1;
        state_nxt  = S_RESP;
      end
      S_DEL_RG: begin
        // bypass the removed slot and fetch the free head together
        nx_wr_en   = 1'b1;
        nx_wr_addr = at_r;
        nx_wr_data = nx_rd_data;
        nx_rd_en   = 1'b1;
        nx_rd_addr = FREE_HEAD;
        state_nxt  = S_DEL_R0;
      end
      S_DEL_R0: begin
        nx_wr_en   = 1'b1;
        nx_wr_addr = slot_r;
        nx_wr_data = nx_rd_data;
        state_nxt  = S_DEL_W0;
      end
      S_DEL_W0: begin
        nx_wr_en   = 1'b1;
        nx_wr_addr = FREE_HEAD;
        nx_wr_data = slot_r;
        count_nxt  = count_r - 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      init_idx_r <= '0;
      count_r    <= '0;
      err_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      init_idx_r <= init_idx_nxt;
      count_r    <= count_nxt;
      err_r      <= err_nxt;
      type_r     <= type_nxt;
      steps_r    <= steps_nxt;
      at_r       <= at_nxt;
      slot_r     <= slot_nxt;
      value_r    <= value_nxt;
    end
  end

  // Length never exceeds the store capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_COUNT)
    else $error("element count above capacity");

  // Inside the list no cursor points at the free head
  a_walk_link: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WSTEP) && ((steps_r != '0) || (type_r == REQ_DELETE))
      |-> (nx_rd_data != FREE_HEAD))
    else $error("list walk hit a null cursor");

  // A linked insert raises the length by exactly one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_LNK) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not bump the length");

  // A deletion lowers the length by exactly one
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL_W0) |=> (count_r == $past(count_r) - 1'b1))
    else $error("delete did not drop the length");

  // Sequencer never reads a cursor it writes in the same cycle
  a_no_rdw: assert property (@(posedge clk) disable iff (!rst_n)
    (nx_wr_en && nx_rd_en) |-> (nx_wr_addr != nx_rd_addr))
    else $error("read and write of one cursor slot together");

endmodule

// ===== tb/sv/slle_list_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the list engine, keeps its own copy of the cursor
// store and compares every result transfer with the oldest reply still due.
module slle_list_checker
  import slle_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_req_type,
  input  logic [POS_W-1:0] in_position,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             out_status,
  input  logic [LEN_W-1:0] out_list_length,
  output int               fail_count,
  output int               pending,
  output int               live_len,
  output int               reject_count,
  output int               peak_len
);

  localparam int unsigned LINK_W    = $clog2(DEPTH);
  localparam int unsigned FREE_HEAD = 0;
  localparam int unsigned LIST_HEAD = DEPTH - 1;

  // Cursor store: slot 0 heads the free chain, the last slot heads the list
  logic [LINK_W-1:0] link_store [DEPTH];
  int unsigned       elem_cnt;
  slle_rsp_t         replies_due [$];
  int                fails   = 0;
  int                rejects = 0;
  int                peak    = 0;

  // Slot just before the one-based position, walked from the list head
  function automatic int unsigned pred_slot(int unsigned pos);
    int unsigned at;
    at = LIST_HEAD;
    for (int unsigned n = 1; n < pos; n++) at = link_store[at];
    return at;
  endfunction

  // Applies one request to the shadow store and returns the reply it earns
  function automatic slle_rsp_t apply_list_op(logic kind, int unsigned pos);
    slle_rsp_t   rsp;
    int unsigned fresh;
    int unsigned pred;
    int unsigned gone;
    rsp.status = STATUS_OK;
    if (kind == REQ_INSERT) begin
      fresh = link_store[FREE_HEAD];
      // bad position or no free slot left
      if (pos < 1 || pos > elem_cnt + 1 || fresh == 0) begin
        rsp.status = STATUS_ERR;
      end else begin
        link_store[FREE_HEAD] = link_store[fresh];
        pred                  = pred_slot(pos);
        link_store[fresh]     = link_store[pred];
        link_store[pred]      = LINK_W'(fresh);
        elem_cnt++;
      end
    end else if (pos < 1 || pos > elem_cnt) begin
      rsp.status = STATUS_ERR;
    end else begin
      // unlink and push the slot back on the free chain
      pred                  = pred_slot(pos);
      gone                  = link_store[pred];
      link_store[pred]      = link_store[gone];
      link_store[gone]      = link_store[FREE_HEAD];
      link_store[FREE_HEAD] = LINK_W'(gone);
      elem_cnt--;
    end
    rsp.list_length = LEN_W'(elem_cnt);
    return rsp;
  endfunction

  always @(posedge clk) begin : watch
    slle_rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) link_store[i] = LINK_W'(i + 1);
      link_store[DEPTH-2] = '0;
      link_store[DEPTH-1] = '0;
      elem_cnt = 0;
      replies_due.delete();
    end else begin
      // request transfer: predict first so order is kept
      if (in_valid && !in_stall) begin
        want = apply_list_op(in_req_type, 32'(in_position));
        if (want.status == STATUS_ERR) rejects++;
        if (int'(elem_cnt) > peak) peak = int'(elem_cnt);
        replies_due.push_back(want);
      end
      // result transfer: compare with the oldest reply due
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result: status %0b, list_length %0d", out_status,
                 out_list_length);
          fails++;
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, out_status);
            fails++;
          end
          if (out_list_length !== want.list_length) begin
            $error("list_length: expected %0d, actual %0d", want.list_length,
                   out_list_length);
            fails++;
          end
        end
      end
    end
    fail_count   <= fails;
    pending      <= replies_due.size();
    live_len     <= int'(elem_cnt);
    reject_count <= rejects;
    peak_len     <= peak;
  end

endmodule

// ===== tb/sv/static_linked_list_engine_tb.sv =====
`timescale 1ns / 1ps

module static_linked_list_engine_tb;
  import slle_pkg::*;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned CAPACITY     = DEPTH - 2;
  localparam int unsigned FILL_LEN     = 300;
  localparam int unsigned POS_MAX      = (1 << POS_W) - 1;
  localparam int          STALL_LIMIT  = 20000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          SETTLE_CYCLES = 1100;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic [POS_W-1:0]   in_position;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic               out_status;
  logic [LEN_W-1:0]   out_list_length;

  int fail_count;
  int pending;
  int live_len;
  int reject_count;
  int peak_len;

  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic hold_req   = 1'b0;
  int   inserts_sent = 0;
  int   deletes_sent = 0;
  int   quiet_cycles = 0;

  static_linked_list_engine #(.DEPTH(DEPTH)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_list_length(out_list_length)
  );

  slle_list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_list_length(out_list_length),
    .fail_count     (fail_count),
    .pending        (pending),
    .live_len       (live_len),
    .reject_count   (reject_count),
    .peak_len       (peak_len)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stalls, or a long hold-off when asked for
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= rx_idle_on && ($urandom_range(0, 99) < 19);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request from a falling edge and returns at the falling edge
  // after its transfer; valid stays high so a following call can reuse it
  task automatic push_request(input logic kind, input int unsigned pos,
                              input logic [VALUE_W-1:0] val);
    while (tx_idle_on && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_position <= POS_W'(pos);
    in_value    <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    if (kind == REQ_INSERT) inserts_sent++;
    else deletes_sent++;
  endtask

  // Sender pause until every reply has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Legal position biased towards both ends
  function automatic int unsigned pick_pos(int unsigned maxp);
    case ($urandom_range(0, 3))
      0:       return 1;
      1:       return maxp;
      default: return $urandom_range(1, maxp);
    endcase
  endfunction

  // Mostly legal inserts and deletes with random content, some out of range
  task automatic push_random_op();
    int unsigned r;
    int unsigned len;
    int unsigned lo;
    int unsigned pos;
    logic        kind;
    len = live_len;
    r   = $urandom_range(0, 99);
    if (r < 12) begin
      kind = 1'($urandom_range(0, 1));
      lo   = (kind == REQ_INSERT) ? len + 2 : len + 1;
      if ($urandom_range(0, 2) == 0 || lo > POS_MAX) pos = 0;
      else pos = $urandom_range(lo, POS_MAX);
    end else if (len == 0 || r < (len > 48 ? 50 : 62)) begin
      kind = REQ_INSERT;
      pos  = pick_pos(len + 1);
    end else begin
      kind = REQ_DELETE;
      pos  = pick_pos(len);
    end
    push_request(kind, pos, $urandom());
  endtask

  initial begin : stimulus
    int unsigned r;
    int unsigned near_end;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_INSERT;
    in_position = '0;
    in_value    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty list: every position is out of range
    push_request(REQ_DELETE, 1, 32'h0);
    push_request(REQ_DELETE, 0, 32'h0);
    push_request(REQ_INSERT, 0, 32'h1);
    push_request(REQ_INSERT, 2, 32'h2);
    push_request(REQ_INSERT, POS_MAX, 32'hFFFF_FFFF);
    push_request(REQ_DELETE, POS_MAX, 32'h0);
    // Build up at head, tail and middle with extreme values
    push_request(REQ_INSERT, 1, 32'h7FFF_FFFF);
    push_request(REQ_INSERT, 2, 32'h8000_0000);
    push_request(REQ_INSERT, 1, 32'h0);
    push_request(REQ_INSERT, 2, 32'hFFFF_FFFF);
    push_request(REQ_INSERT, 6, 32'h1234_5678);
    push_request(REQ_INSERT, 5, 32'h5555_5555);
    // Remove last, first and middle; one past the end is rejected
    push_request(REQ_DELETE, 5, 32'h0);
    push_request(REQ_DELETE, 5, 32'h0);
    push_request(REQ_DELETE, 1, 32'h0);
    push_request(REQ_DELETE, 2, 32'hFFFF_FFFF);
    push_request(REQ_INSERT, 3, 32'hAAAA_AAAA);
    push_request(REQ_DELETE, 0, 32'h0);
    push_request(REQ_INSERT, 0, 32'h0);
    wait_drained();

    // Random mix on a short list; one long receiver hold-off and a stretch
    // with no idling on either side
    for (int k = 0; k < 200; k++) begin
      if (k == 30) hold_req = 1'b1;
      tx_idle_on = !(k >= 110 && k < 170);
      rx_idle_on = tx_idle_on;
      push_random_op();
    end
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // Grow the list to a few hundred elements, mostly near the head
    while (live_len < FILL_LEN) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        push_random_op();
      end else if (r < 7) begin
        push_request(REQ_INSERT, live_len + 1, $urandom());
      end else begin
        near_end = (live_len + 1 < 16) ? live_len + 1 : 16;
        push_request(REQ_INSERT, $urandom_range(1, near_end), $urandom());
      end
    end

    // Long list: walks to the tail, one past either end is rejected
    push_request(REQ_INSERT, live_len + 2, $urandom());
    push_request(REQ_INSERT, live_len + 1, $urandom());
    push_request(REQ_DELETE, live_len + 1, $urandom());
    push_request(REQ_DELETE, live_len, $urandom());
    push_request(REQ_INSERT, 0, $urandom());
    push_request(REQ_DELETE, 1, $urandom());
    push_request(REQ_INSERT, 1, $urandom());

    // Random mix on the long list
    for (int k = 0; k < 40; k++) push_random_op();
    wait_drained();

    // Let any late or stray result show up
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("summary: %0d requests, %0d inserts and %0d deletes, %0d rejected",
             inserts_sent + deletes_sent, inserts_sent, deletes_sent, reject_count);
    $display("summary: peak length %0d of %0d slots, long walks to both list ends",
             peak_len, CAPACITY);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/slle_pkg.sv
design/slle_ram.sv
design/slle_ctrl.sv
design/static_linked_list_engine.sv
tb/sv/slle_list_checker.sv
tb/sv/static_linked_list_engine_tb.sv
